### hw/rtl/lgr_pkg.sv
// ----------------------------------------------------------------------------
// lgr_pkg - shared types and constants for the Life row stream
// Row width, register reset value, rule thresholds, the neighbor bundle
// passed between column cells and the result queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgr_pkg;

    // Fixed port widths
    localparam int ROW_BITS   = 64;
    localparam int WIDTH_BITS = 7;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;

    // B3/S23 thresholds
    localparam logic [3:0] LIFE_BIRTH = 4'd3;
    localparam logic [3:0] LIFE_STAY  = 4'd2;

    // Result queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Masked bits of one column, handed to both neighbors
    typedef struct packed {
        logic upper;
        logic middle;
        logic cur;
    } t_col;

    // Per-beat control broadcast to every cell
    typedef struct packed {
        logic load;
        logic clear;
    } t_cell_ctl;

    // One queued result beat
    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                last;
    } t_result;

    // Next state of one cell from its eight neighbors
    function automatic logic life_rule(input logic alive, input logic [7:0] nbrs);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(nbrs[i]);
        end
        return (n == LIFE_BIRTH) || (alive && (n == LIFE_STAY));
    endfunction

endpackage

`default_nettype wire

### hw/rtl/life_generation_row_stream.sv
// ----------------------------------------------------------------------------
// life_generation_row_stream - one Life generation (B3/S23) per row stream
// A row of column cells holds the two previous rows; each input beat yields
// the next generation of the pending row, if any, and on the last row also its own.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_row_cells, i_last_row
//  out     | output    | o_out_valid / i_out_ready| o_next_row_cells, o_last_out
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_width_in_use
//
//  One row beat per cycle; all columns are computed in parallel by the cells.
//  Results pass through a 4-entry queue; a last row pushes two beats, so
//  input is taken while at most two entries are occupied.
//  Output drains one beat per cycle; a stalled output fills the queue and
//  then holds off input. Reset is synchronous: rows cleared, width 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module life_generation_row_stream
    import lgr_pkg::*;
#(
    parameter int ROW_CELLS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [ROW_BITS-1:0]   i_row_cells,
    input  wire logic                  i_last_row,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [ROW_BITS-1:0]        o_next_row_cells,
    output logic                       o_last_out,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [WIDTH_BITS-1:0] i_cfg_width_in_use
);

    logic [WIDTH_BITS-1:0] r_width;
    logic                  r_mid_valid;
    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    logic [FIFO_PTR_W-1:0] n_wr_ptr;
    logic [FIFO_PTR_W-1:0] w_wr_ptr1;
    logic [FIFO_CNT_W-1:0] n_count;
    logic                  w_accept;
    logic                  w_pop;
    logic                  w_push0;
    logic                  w_push1;
    t_cell_ctl             w_ctl;
    t_col                  w_col [ROW_CELLS];
    logic [ROW_BITS-1:0]   w_next_mid;
    logic [ROW_BITS-1:0]   w_next_last;
    t_result               w_entry0;
    t_result               w_entry1;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign w_accept    = i_in_valid & o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign w_pop       = o_out_valid & i_out_ready;

    assign w_ctl.load  = w_accept;
    assign w_ctl.clear = i_last_row;

    // Width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_width_in_use;
        end
    end

    // Pending row flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (w_accept) begin
            r_mid_valid <= ~i_last_row;
        end
    end

    // Column cells; columns past ROW_CELLS are always dead
    for (genvar k = 0; k < ROW_BITS; k++) begin : g_col
        if (k < ROW_CELLS) begin : g_cell
            t_col w_left;
            t_col w_right;
            if (k == 0) begin : g_ledge
                assign w_left = '0;
            end else begin : g_lnbr
                assign w_left = w_col[k-1];
            end
            if (k == ROW_CELLS - 1) begin : g_redge
                assign w_right = '0;
            end else begin : g_rnbr
                assign w_right = w_col[k+1];
            end
            lgr_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_active    (r_width > WIDTH_BITS'(k)),
                .i_cur       (i_row_cells[k]),
                .i_left      (w_left),
                .i_right     (w_right),
                .o_col       (w_col[k]),
                .o_next_mid  (w_next_mid[k]),
                .o_next_last (w_next_last[k])
            );
        end else begin : g_dead
            assign w_next_mid[k]  = 1'b0;
            assign w_next_last[k] = 1'b0;
        end
    end

    // Result beats; the pending row is all zero when no row is pending
    assign w_push0        = r_mid_valid | i_last_row;
    assign w_push1        = r_mid_valid & i_last_row;
    assign w_entry0.cells = r_mid_valid ? w_next_mid : w_next_last;
    assign w_entry0.last  = ~r_mid_valid;
    assign w_entry1.cells = w_next_last;
    assign w_entry1.last  = 1'b1;

    // Queue pointers and occupancy
    assign w_wr_ptr1 = r_wr_ptr + FIFO_PTR_W'(1);
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (w_accept) begin
            n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(w_push0) + FIFO_PTR_W'(w_push1);
            n_count  = n_count + FIFO_CNT_W'(w_push0) + FIFO_CNT_W'(w_push1);
        end
        if (w_pop) begin
            n_count = n_count - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_accept && w_push0) begin
            r_fifo[r_wr_ptr] <= w_entry0;
        end
        if (w_accept && w_push1) begin
            r_fifo[w_wr_ptr1] <= w_entry1;
        end
    end

    assign o_next_row_cells = r_fifo[r_rd_ptr].cells;
    assign o_last_out       = r_fifo[r_rd_ptr].last;

endmodule

`default_nettype wire

### hw/rtl/lgr_cell.sv
// ----------------------------------------------------------------------------
// lgr_cell - one column of the Life row stream
// Holds this column's bit of the upper and pending rows, shares its masked
// bits with the left and right cells, and computes both candidate results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgr_cell
    import lgr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_active,
    input  wire logic      i_cur,
    input  wire t_col      i_left,
    input  wire t_col      i_right,
    output t_col           o_col,
    output logic           o_next_mid,
    output logic           o_next_last
);

    logic r_upper;
    logic r_middle;
    logic w_cur;

    // Columns beyond the active width read as dead
    assign w_cur        = i_cur & i_active;
    assign o_col.upper  = r_upper & i_active;
    assign o_col.middle = r_middle & i_active;
    assign o_col.cur    = w_cur;

    // Pending row: upper above, incoming row below
    assign o_next_mid = i_active & life_rule(o_col.middle,
        {i_left.upper, o_col.upper, i_right.upper,
         i_left.middle, i_right.middle,
         i_left.cur, w_cur, i_right.cur});

    // Incoming row as the last one: pending above, dead below
    assign o_next_last = i_active & life_rule(w_cur,
        {i_left.middle, o_col.middle, i_right.middle,
         i_left.cur, i_right.cur,
         3'b000});

    // Shift the column down one row per accepted beat; the last row clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper  <= 1'b0;
            r_middle <= 1'b0;
        end else if (i_ctl.load) begin
            if (i_ctl.clear) begin
                r_upper  <= 1'b0;
                r_middle <= 1'b0;
            end else begin
                r_upper  <= r_middle;
                r_middle <= w_cur;
            end
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for life_generation_row_stream
// Streams grids of rows through the block and predicts every next-generation
// row in the bench itself, including row store, width register and edges.
// Covers single-row grids, edge columns, width extremes and saturation,
// width changes mid-grid, random grids under random idling on both
// channels, and a long output stall that backs the block up into its input.
// ----------------------------------------------------------------------------

module tb;
    import lgr_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 9;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 8;
    localparam int STALL_TICKS  = 150;
    localparam int RANDOM_ROWS  = 640;
    localparam int BIRTH_COUNT  = 3;
    localparam int STAY_COUNT   = 2;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ROW_BITS-1:0]   in_cells;
    logic                  in_last;
    logic                  out_valid;
    logic                  out_ready;
    logic [ROW_BITS-1:0]   out_cells;
    logic                  out_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [WIDTH_BITS-1:0] cfg_width;

    // Bench copy of the block state
    logic [WIDTH_BITS-1:0] gen_width;
    logic [ROW_BITS-1:0]   gen_upper;
    logic [ROW_BITS-1:0]   gen_middle;
    logic                  gen_pending;
    t_result               gen_queue[$];

    // Idle control: no_idle is shared by both sides, hold_left holds off the receiver
    bit no_idle;
    int hold_left;

    int errors;
    int rows_sent;
    int grids_sent;
    int gens_checked;
    int width_writes;

    life_generation_row_stream u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_row_cells        (in_cells),
        .i_last_row         (in_last),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_next_row_cells   (out_cells),
        .o_last_out         (out_last),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_width_in_use (cfg_width)
    );

    always begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------------
    // Next-generation prediction
    // ------------------------------------------------------------------------
    function automatic logic [ROW_BITS-1:0] width_mask(input logic [WIDTH_BITS-1:0] w);
        if (w >= ROW_BITS) begin
            return '1;
        end
        return (64'd1 << w) - 64'd1;
    endfunction

    // Out-of-row columns read as dead
    function automatic int cell_at(input logic [ROW_BITS-1:0] r, input int k);
        if (k < 0 || k >= ROW_BITS) begin
            return 0;
        end
        return int'(r[k]);
    endfunction

    function automatic logic [ROW_BITS-1:0] life_next_row(
        input logic [ROW_BITS-1:0] above,
        input logic [ROW_BITS-1:0] here,
        input logic [ROW_BITS-1:0] below,
        input logic [ROW_BITS-1:0] mask
    );
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] h;
        logic [ROW_BITS-1:0] b;
        logic [ROW_BITS-1:0] res;
        int                  n;
        a   = above & mask;
        h   = here & mask;
        b   = below & mask;
        res = '0;
        for (int k = 0; k < ROW_BITS; k++) begin
            n = cell_at(a, k - 1) + cell_at(a, k) + cell_at(a, k + 1)
              + cell_at(h, k - 1) + cell_at(h, k + 1)
              + cell_at(b, k - 1) + cell_at(b, k) + cell_at(b, k + 1);
            if (n == BIRTH_COUNT || (h[k] && n == STAY_COUNT)) begin
                res[k] = 1'b1;
            end
        end
        return res & mask;
    endfunction

    // Advance the row store by one accepted beat and queue its results
    function automatic void take_row(input logic [ROW_BITS-1:0] cells, input logic last);
        logic [ROW_BITS-1:0] mask;
        logic [ROW_BITS-1:0] cur;
        mask = width_mask(gen_width);
        cur  = cells & mask;
        if (gen_pending) begin
            gen_queue.push_back('{cells: life_next_row(gen_upper, gen_middle, cur, mask),
                                  last: 1'b0});
            if (last) begin
                gen_queue.push_back('{cells: life_next_row(gen_middle, cur, '0, mask),
                                      last: 1'b1});
            end
        end else if (last) begin
            gen_queue.push_back('{cells: life_next_row('0, cur, '0, mask), last: 1'b1});
        end
        if (last) begin
            gen_upper   = '0;
            gen_middle  = '0;
            gen_pending = 1'b0;
        end else begin
            gen_upper   = gen_pending ? gen_middle : '0;
            gen_middle  = cur;
            gen_pending = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Row sender: called at a falling edge, returns at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_cells = cells;
        in_last  = last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        take_row(cells, last);
        rows_sent++;
        if (last) begin
            grids_sent++;
        end
        @(negedge clk);
    endtask

    // Drop input, drain all results, then let the pipeline settle
    task automatic quiesce();
        in_valid = 1'b0;
        while (gen_queue.size() != 0) @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_BITS-1:0] w);
        quiesce();
        cfg_valid = 1'b1;
        cfg_width = w;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        gen_width = w;
        width_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [ROW_BITS-1:0] rand_row();
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return a & b;
            1: return a | b;
            2: return a & b & {$urandom, $urandom};
            3: return {a[63:60], 56'd0, b[3:0]};
            default: return a;
        endcase
    endfunction

    function automatic logic [WIDTH_BITS-1:0] rand_width();
        case ($urandom_range(0, 7))
            0: return WIDTH_BITS'($urandom_range(0, 1));
            1: return $urandom_range(0, 1) ? 7'd64 : 7'd127;
            2: return WIDTH_BITS'($urandom_range(65, 127));
            default: return WIDTH_BITS'($urandom_range(1, 64));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_single_row_grids();
        send_row(64'h0, 1'b1);
        send_row('1, 1'b1);
        send_row(64'h7, 1'b1);
        send_row(64'hC000_0000_0000_0003, 1'b1);
    endtask

    task automatic test_edge_patterns();
        // corner columns on three rows
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        // full and empty rows alternating
        send_row('1, 1'b0);
        send_row(64'h0, 1'b0);
        send_row('1, 1'b1);
        // blinker
        send_row(64'h0, 1'b0);
        send_row(64'h38, 1'b0);
        send_row(64'h0, 1'b1);
        // two-row grid
        send_row(64'hAAAA_5555_F0F0_0F0F, 1'b0);
        send_row(64'h5555_AAAA_0F0F_F0F0, 1'b1);
    endtask

    task automatic test_width_extremes();
        write_width(7'd0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        write_width(7'd1);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        write_width(7'd127);
        send_row('1, 1'b0);
        send_row(64'h5A5A_5A5A_5A5A_5A5A, 1'b1);
        write_width(7'd33);
        send_row('1, 1'b0);
        send_row(64'hFFFF_FFFF_0000_0007, 1'b1);
        write_width(7'd64);
    endtask

    task automatic test_width_change_mid_grid();
        send_row(64'h0000_00FF_FFFF_FFFF, 1'b0);
        send_row(64'h0000_00FF_FFFF_FFFF, 1'b0);
        write_width(7'd8);
        send_row('1, 1'b0);
        write_width(7'd64);
        send_row('1, 1'b1);
    endtask

    // Receiver holds off while the sender keeps pushing rows
    task automatic test_output_stall();
        quiesce();
        hold_left = STALL_TICKS;
        no_idle   = 1'b1;
        for (int i = 0; i < 24; i++) begin
            send_row(rand_row(), (i % 4) == 3);
        end
        no_idle = 1'b0;
        quiesce();
    endtask

    task automatic test_random_grids();
        int height;
        int start;
        start = rows_sent;
        while (rows_sent - start < RANDOM_ROWS) begin
            if ($urandom_range(0, 5) == 0) begin
                write_width(rand_width());
            end
            no_idle = ($urandom_range(0, 5) == 0);
            height  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                  : $urandom_range(1, 8);
            for (int r = 0; r < height; r++) begin
                if (r > 0 && $urandom_range(0, 24) == 0) begin
                    write_width(rand_width());
                end
                send_row(rand_row(), r == height - 1);
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready gaps, plus a counted hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        out_ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            while (gap > 0 || hold_left > 0) begin
                out_ready = 1'b0;
                if (hold_left > 0) begin
                    hold_left--;
                end else begin
                    gap--;
                end
                @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid && hold_left == 0) @(posedge clk);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: sample at the edge, compare once predictions are in
    // ------------------------------------------------------------------------
    initial begin
        t_result got;
        t_result want;
        bit      fire;
        forever begin
            @(posedge clk);
            fire      = rst_n && out_valid && out_ready;
            got.cells = out_cells;
            got.last  = out_last;
            #1;
            if (fire) begin
                if (gen_queue.size() == 0) begin
                    errors++;
                    $display("%0t: expected no beat, got cells=%h last=%b",
                             $time, got.cells, got.last);
                end else begin
                    want = gen_queue.pop_front();
                    gens_checked++;
                    if (got.cells !== want.cells) begin
                        errors++;
                        $display("%0t: next_row_cells expected %h got %h",
                                 $time, want.cells, got.cells);
                    end
                    if (got.last !== want.last) begin
                        errors++;
                        $display("%0t: last_out expected %b got %b",
                                 $time, want.last, got.last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_cells     = '0;
        in_last      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_width    = '0;
        no_idle      = 1'b0;
        hold_left    = 0;
        errors       = 0;
        rows_sent    = 0;
        grids_sent   = 0;
        gens_checked = 0;
        width_writes = 0;
        gen_width    = WIDTH_RESET;
        gen_upper    = '0;
        gen_middle   = '0;
        gen_pending  = 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_row_grids();
        test_edge_patterns();
        test_width_extremes();
        test_width_change_mid_grid();
        test_output_stall();
        test_random_grids();

        quiesce();
        $display("Streamed %0d rows in %0d grids, checked %0d generation rows, %0d width writes",
                 rows_sent, grids_sent, gens_checked, width_writes);
        $display("Included single-row grids, width 0/1/127, mid-grid width changes, output stall");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
